// ----- rtl/feedback_queue_scheduler_unit_assert.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef FEEDBACK_QUEUE_SCHEDULER_UNIT_ASSERT_SVH
`define FEEDBACK_QUEUE_SCHEDULER_UNIT_ASSERT_SVH
// Condition must hold at every edge out of reset.
`define FQS_AST_HOLD(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Trigger at one edge implies the result at the next.
`define FQS_AST_NEXT(lbl, trig, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) else $error(msg);
`endif

// ----- rtl/fqs_pkg.sv -----
// Shared constants and types of the feedback queue scheduler.
`default_nettype none
package fqs_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = 4;
	localparam int TIME_W = 16;
	localparam int LVL_W = 3;
	localparam int CNT_W = 5;
	localparam logic [LVL_W-1:0] TOP_QUEUED_LEVEL = 3'd5;

	localparam logic [1:0] ST_NOT_ARRIVED = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [2:0] EV_START = 3'd0;
	localparam logic [2:0] EV_RESUME = 3'd1;
	localparam logic [2:0] EV_SUSPEND = 3'd2;
	localparam logic [2:0] EV_FINISH = 3'd3;
	localparam logic [2:0] EV_TIMEOUT = 3'd4;
	localparam logic [2:0] EV_ALLDONE = 3'd5;

	localparam logic [1:0] REG_TASK_COUNT = 2'd0;
	localparam logic [1:0] REG_WAIT_LIMIT = 2'd1;
	localparam logic [1:0] REG_LOWEST_LEVEL = 2'd2;

	typedef struct packed {
		logic [2:0] event_res;
		logic [SLOT_W-1:0] task_res;
		logic [LVL_W-1:0] task_level;
		logic [TIME_W-1:0] remaining;
	} fqs_evt_t;
endpackage
`default_nettype wire

// ----- rtl/fqs_if.sv -----
// Request and result channel interfaces of the scheduler.
`default_nettype none
interface fqs_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [3:0] slot;
	logic [15:0] arrival;
	logic [15:0] burst;
	logic [2:0] level;
	modport source (output valid, mode, slot, arrival, burst, level, input ready);
	modport sink (input valid, mode, slot, arrival, burst, level, output ready);
endinterface

interface fqs_out_if;
	logic valid;
	logic ready;
	logic [2:0] event_res;
	logic [3:0] task_res;
	logic [2:0] task_level;
	logic [15:0] remaining;
	logic [15:0] now;
	logic last;
	modport source (output valid, event_res, task_res, task_level, remaining, now, last,
		input ready);
	modport sink (input valid, event_res, task_res, task_level, remaining, now, last,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/feedback_queue_scheduler_unit.sv -----
// Multilevel feedback queue scheduler: task table, tick sequencer and result register.
// Usage:
//   in_ch carries requests. mode 0 loads a task slot (arrival, burst, level) and
//   gives no result. mode 1 runs one scheduler tick.
//   out_ch carries the events of a tick; last marks the final event of the tick.
//   The APB port sets task_count (0x0), wait_limit (0x4) and lowest_level (0x8).
// Timing:
//   A tick walks the used slots three times through one shared slot read port, one
//   slot a cycle unless stalled: admission, selection, timeout. in_ch.ready is low
//   for the whole tick. Events leave through a one-entry hold stage and an output
//   register; the last event of a tick leaves the hold stage after the final scan.
// Reset: all slots read as not arrived, queue times and tick time clear, nothing runs,
//   registers take task_count 0, wait_limit 20, lowest_level 5.
// Stall: when out_ch.ready is low, both result stages are full and another event must move,
//   the sequencer holds in place until the receiver takes a result; nothing is dropped.
`default_nettype none
module feedback_queue_scheduler_unit (
	input wire logic clk,
	input wire logic arst_n,
	fqs_in_if.sink in_ch,
	fqs_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import fqs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADMIT = 3'd1;
	localparam logic [2:0] S_CHARGE = 3'd2;
	localparam logic [2:0] S_SELECT = 3'd3;
	localparam logic [2:0] S_SEL_EMIT = 3'd4;
	localparam logic [2:0] S_TMO = 3'd5;
	localparam logic [2:0] S_ALLDONE = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [4:0] task_count_q;
	logic [15:0] wait_limit_q;
	logic [2:0] lowest_level_q;

	logic [TIME_W-1:0] arrive_q [NUM_SLOTS];
	logic [TIME_W-1:0] burst_q [NUM_SLOTS];
	logic [TIME_W-1:0] work_q [NUM_SLOTS];
	logic [LVL_W-1:0] lvl_q [NUM_SLOTS];
	logic [1:0] status_q [NUM_SLOTS];
	logic [TIME_W-1:0] enq_q [NUM_SLOTS];

	logic [2:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] run_q;
	logic run_valid_q;
	logic [LVL_W-1:0] run_level_q;
	logic [TIME_W-1:0] now_q;
	logic all_done_q;

	logic best_v_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [LVL_W-1:0] best_lvl_q;
	logic [TIME_W-1:0] best_key_q;
	logic [TIME_W-1:0] best_burst_q;
	logic [TIME_W-1:0] best_work_q;

	logic pend_valid_q;
	fqs_evt_t pend_q;
	logic out_valid_q;
	fqs_evt_t out_q;
	logic out_last_q;
	logic [TIME_W-1:0] out_now_q;

	// config port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_TASK_COUNT: prdata = {27'd0, task_count_q};
			REG_WAIT_LIMIT: prdata = {16'd0, wait_limit_q};
			REG_LOWEST_LEVEL: prdata = {29'd0, lowest_level_q};
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= 5'd0;
			wait_limit_q <= 16'd20;
			lowest_level_q <= 3'd5;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TASK_COUNT: task_count_q <= pwdata[4:0];
				REG_WAIT_LIMIT: wait_limit_q <= pwdata[15:0];
				REG_LOWEST_LEVEL: lowest_level_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// shared slot read port
	logic [CNT_W-1:0] used;
	logic scan_on;
	logic [SLOT_W-1:0] rd;
	logic [TIME_W-1:0] rd_arr, rd_burst, rd_work, rd_enq;
	logic [LVL_W-1:0] rd_lvl;
	logic [1:0] rd_st;

	assign used = (task_count_q > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : task_count_q;
	assign scan_on = cnt_q < used;
	assign rd = (state_q == S_CHARGE) ? run_q : cnt_q[SLOT_W-1:0];
	assign rd_arr = arrive_q[rd];
	assign rd_burst = burst_q[rd];
	assign rd_work = work_q[rd];
	assign rd_enq = enq_q[rd];
	assign rd_lvl = lvl_q[rd];
	assign rd_st = status_q[rd];

	// selection compare
	logic sel_cand, sel_better;
	logic [TIME_W-1:0] sel_key;
	assign sel_cand = (rd_st == ST_READY) && (rd_lvl <= TOP_QUEUED_LEVEL);
	assign sel_key = (rd_lvl == '0) ? '0 : rd_enq;
	assign sel_better = !best_v_q || (rd_lvl < best_lvl_q)
		|| ((rd_lvl == best_lvl_q) && (sel_key < best_key_q));

	// timeout compare: waited = (now - arrival) - (burst - work_left)
	logic signed [TIME_W+2:0] waited;
	logic tmo_hit;
	assign waited = $signed({3'b000, now_q}) - $signed({3'b000, rd_arr})
		- $signed({3'b000, rd_burst}) + $signed({3'b000, rd_work});
	assign tmo_hit = scan_on && (rd_st == ST_READY)
		&& !(run_valid_q && (rd == run_q))
		&& (waited >= $signed({3'b000, wait_limit_q}))
		&& !(run_valid_q && (rd_lvl == run_level_q));

	// charge step
	logic [LVL_W-1:0] ch_lvl;
	logic [TIME_W-1:0] ch_work;
	assign ch_work = rd_work - 1'b1;
	assign ch_lvl = (rd_lvl < lowest_level_q) ? rd_lvl + 1'b1 : rd_lvl;

	// event request
	logic emit;
	fqs_evt_t emit_ev;
	always_comb begin
		emit = 1'b0;
		emit_ev = '0;
		case (state_q)
			S_CHARGE: begin
				if (run_valid_q && rd_st != ST_DONE) begin
					if (rd_work <= 16'd1) begin
						emit = 1'b1;
						emit_ev = '{EV_FINISH, run_q, rd_lvl, '0};
					end else if (rd_lvl != '0) begin
						emit = 1'b1;
						emit_ev = '{EV_SUSPEND, run_q, ch_lvl, ch_work};
					end
				end
			end
			S_SEL_EMIT: begin
				if (best_v_q) begin
					emit = 1'b1;
					emit_ev = '{(best_burst_q == best_work_q) ? EV_START : EV_RESUME,
						best_slot_q, best_lvl_q, best_work_q};
				end
			end
			S_TMO: begin
				if (tmo_hit) begin
					emit = 1'b1;
					emit_ev = '{EV_TIMEOUT, rd, rd_lvl, rd_work};
				end
			end
			S_ALLDONE: begin
				if (all_done_q && used != '0) begin
					emit = 1'b1;
					emit_ev = '{EV_ALLDONE, '0, '0, '0};
				end
			end
			default: ;
		endcase
	end

	logic out_free, go;
	assign out_free = !out_valid_q || out_ch.ready;
	assign go = !(emit && pend_valid_q && !out_free)
		&& !(state_q == S_FLUSH && pend_valid_q && !out_free);

	assign in_ch.ready = (state_q == S_IDLE);

	// slot table payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready && !in_ch.mode) begin
			arrive_q[in_ch.slot] <= in_ch.arrival;
			burst_q[in_ch.slot] <= in_ch.burst;
			work_q[in_ch.slot] <= in_ch.burst;
			lvl_q[in_ch.slot] <= in_ch.level;
		end else if (state_q == S_CHARGE && go && run_valid_q && rd_st != ST_DONE) begin
			if (rd_work <= 16'd1) begin
				work_q[rd] <= '0;
			end else begin
				work_q[rd] <= ch_work;
				if (rd_lvl != '0) lvl_q[rd] <= ch_lvl;
			end
		end
	end

	// sequencer, status and queue times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			run_q <= '0;
			run_valid_q <= 1'b0;
			run_level_q <= '0;
			now_q <= '0;
			all_done_q <= 1'b0;
			best_v_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				status_q[i] <= ST_NOT_ARRIVED;
				enq_q[i] <= '0;
			end
		end else if (go) begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_ch.valid) begin
						if (in_ch.mode) state_q <= S_ADMIT;
						else status_q[in_ch.slot] <= ST_NOT_ARRIVED;
					end
				end
				S_ADMIT: begin
					if (scan_on) begin
						cnt_q <= cnt_q + 1'b1;
						if (rd_st == ST_NOT_ARRIVED && rd_arr == now_q) begin
							status_q[rd] <= ST_READY;
							enq_q[rd] <= now_q;
						end
					end else begin
						cnt_q <= '0;
						state_q <= S_CHARGE;
					end
				end
				S_CHARGE: begin
					best_v_q <= 1'b0;
					state_q <= S_SELECT;
					if (run_valid_q) begin
						if (rd_st == ST_DONE) begin
							run_valid_q <= 1'b0;
						end else if (rd_work <= 16'd1) begin
							status_q[rd] <= ST_DONE;
							run_valid_q <= 1'b0;
						end else if (rd_lvl != '0) begin
							enq_q[rd] <= now_q;
						end
					end
				end
				S_SELECT: begin
					if (scan_on) begin
						cnt_q <= cnt_q + 1'b1;
						if (sel_cand && sel_better) begin
							best_v_q <= 1'b1;
							best_slot_q <= rd;
							best_lvl_q <= rd_lvl;
							best_key_q <= sel_key;
							best_burst_q <= rd_burst;
							best_work_q <= rd_work;
						end
					end else begin
						cnt_q <= '0;
						state_q <= S_SEL_EMIT;
					end
				end
				S_SEL_EMIT: begin
					run_valid_q <= best_v_q;
					if (best_v_q) begin
						run_q <= best_slot_q;
						run_level_q <= best_lvl_q;
					end
					all_done_q <= 1'b1;
					state_q <= S_TMO;
				end
				S_TMO: begin
					if (scan_on) begin
						cnt_q <= cnt_q + 1'b1;
						if (tmo_hit) status_q[rd] <= ST_DONE;
						else if (rd_st != ST_DONE) all_done_q <= 1'b0;
					end else begin
						cnt_q <= '0;
						state_q <= S_ALLDONE;
					end
				end
				S_ALLDONE: state_q <= S_FLUSH;
				S_FLUSH: begin
					state_q <= S_IDLE;
					if (now_q != '1) now_q <= now_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold stage keeps one event back so the tick's final one can be marked last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit && go) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) out_valid_q <= 1'b1;
				else if (out_ch.ready) out_valid_q <= 1'b0;
			end else if (state_q == S_FLUSH && go && pend_valid_q) begin
				pend_valid_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && go) begin
			pend_q <= emit_ev;
			if (pend_valid_q) begin
				out_q <= pend_q;
				out_last_q <= 1'b0;
				out_now_q <= now_q;
			end
		end else if (state_q == S_FLUSH && go && pend_valid_q) begin
			out_q <= pend_q;
			out_last_q <= 1'b1;
			out_now_q <= now_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.event_res = out_q.event_res;
	assign out_ch.task_res = out_q.task_res;
	assign out_ch.task_level = out_q.task_level;
	assign out_ch.remaining = out_q.remaining;
	assign out_ch.now = out_now_q;
	assign out_ch.last = out_last_q;

`include "feedback_queue_scheduler_unit_assert.svh"
	`FQS_AST_HOLD(a_pend_idle, (state_q != S_IDLE) || !pend_valid_q, "event held while idle")
	`FQS_AST_HOLD(a_cnt_range, cnt_q <= CNT_W'(NUM_SLOTS), "scan counter out of range")
	`FQS_AST_NEXT(a_tick_start, in_ch.valid && in_ch.ready && in_ch.mode,
		state_q == S_ADMIT, "tick did not start admission")
endmodule
`default_nettype wire

// ----- tb/feedback_queue_scheduler_unit_tb.sv -----
// Self-checking testbench of the feedback queue scheduler: random requests, APB setup, event check.
`timescale 1ns / 100ps
`default_nettype none
module feedback_queue_scheduler_unit_tb;
	import fqs_pkg::*;

	typedef struct {
		logic mode;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [LVL_W-1:0] level;
	} sched_req_t;

	typedef struct {
		logic [2:0] event_res;
		logic [SLOT_W-1:0] task_res;
		logic [LVL_W-1:0] task_level;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] now;
		logic last;
	} sched_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	fqs_in_if in_ch ();
	fqs_out_if out_ch ();

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = 1'b0;
		in_ch.slot = '0;
		in_ch.arrival = '0;
		in_ch.burst = '0;
		in_ch.level = '0;
		out_ch.ready = 1'b0;
	end

	feedback_queue_scheduler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// scheduler shadow state
	logic [CNT_W-1:0] cfg_task_count = 5'd0;
	logic [TIME_W-1:0] cfg_wait_limit = 16'd20;
	logic [LVL_W-1:0] cfg_lowest_level = 3'd5;
	logic [TIME_W-1:0] sh_arrive [NUM_SLOTS];
	logic [TIME_W-1:0] sh_burst [NUM_SLOTS];
	logic [TIME_W-1:0] sh_left [NUM_SLOTS];
	logic [LVL_W-1:0] sh_level [NUM_SLOTS];
	logic [1:0] sh_status [NUM_SLOTS];
	logic [TIME_W-1:0] sh_enq [NUM_SLOTS];
	logic [SLOT_W-1:0] sh_run_slot = '0;
	logic sh_run_valid = 1'b0;
	logic [TIME_W-1:0] sh_tick = '0;

	sched_req_t pending_reqs[$];
	sched_event_t expected_events[$];
	int errors = 0;
	int gen_tick = 0;

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			sh_status[i] = ST_NOT_ARRIVED;
			sh_enq[i] = '0;
			sh_arrive[i] = '0;
			sh_burst[i] = '0;
			sh_left[i] = '0;
			sh_level[i] = '0;
		end
	end

	task automatic add_event(logic [2:0] ev, int s, logic [LVL_W-1:0] lv,
			logic [TIME_W-1:0] rem, logic [TIME_W-1:0] t);
		sched_event_t e;
		e.event_res = ev;
		e.task_res = s[SLOT_W-1:0];
		e.task_level = lv;
		e.remaining = rem;
		e.now = t;
		e.last = 1'b0;
		expected_events.push_back(e);
	endtask

	function automatic int pick_next_task(int used);
		int sel;
		for (int i = 0; i < used; i++)
			if (sh_status[i] == ST_READY && sh_level[i] == 0) return i;
		for (int p = 1; p <= TOP_QUEUED_LEVEL; p++) begin
			sel = -1;
			for (int i = 0; i < used; i++)
				if (sh_status[i] == ST_READY && sh_level[i] == p)
					if (sel < 0 || sh_enq[i] < sh_enq[sel]) sel = i;
			if (sel >= 0) return sel;
		end
		return -1;
	endfunction

	task automatic schedule_request(sched_req_t rq);
		int used;
		int sel;
		int r;
		int waited;
		int first;
		bit all_done;
		logic [TIME_W-1:0] now;
		used = (cfg_task_count > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_task_count);
		now = sh_tick;
		first = expected_events.size();
		if (rq.mode == 1'b0) begin
			sh_arrive[rq.slot] = rq.arrival;
			sh_burst[rq.slot] = rq.burst;
			sh_left[rq.slot] = rq.burst;
			sh_level[rq.slot] = rq.level;
			sh_status[rq.slot] = ST_NOT_ARRIVED;
			return;
		end
		for (int i = 0; i < used; i++)
			if (sh_status[i] == ST_NOT_ARRIVED && sh_arrive[i] == now) begin
				sh_status[i] = ST_READY;
				sh_enq[i] = now;
			end
		if (sh_run_valid) begin
			r = int'(sh_run_slot);
			if (sh_status[r] == ST_DONE) begin
				sh_run_valid = 1'b0;
			end else if (sh_left[r] <= 1) begin
				sh_left[r] = '0;
				sh_status[r] = ST_DONE;
				add_event(EV_FINISH, r, sh_level[r], '0, now);
				sh_run_valid = 1'b0;
			end else begin
				sh_left[r] = sh_left[r] - 1'b1;
				if (sh_level[r] > 0) begin
					if (sh_level[r] < cfg_lowest_level) sh_level[r] = sh_level[r] + 1'b1;
					sh_enq[r] = now;
					add_event(EV_SUSPEND, r, sh_level[r], sh_left[r], now);
				end
			end
		end
		sel = pick_next_task(used);
		if (sel >= 0) begin
			add_event((sh_burst[sel] == sh_left[sel]) ? EV_START : EV_RESUME,
				sel, sh_level[sel], sh_left[sel], now);
			sh_run_slot = sel[SLOT_W-1:0];
			sh_run_valid = 1'b1;
		end else begin
			sh_run_valid = 1'b0;
		end
		for (int i = 0; i < used; i++) begin
			if (sh_status[i] != ST_READY) continue;
			if (sh_run_valid && i == sh_run_slot) continue;
			waited = (int'(now) - int'(sh_arrive[i])) - (int'(sh_burst[i]) - int'(sh_left[i]));
			if (waited >= int'(cfg_wait_limit)) begin
				if (sh_run_valid && sh_level[i] == sh_level[sh_run_slot]) continue;
				sh_status[i] = ST_DONE;
				add_event(EV_TIMEOUT, i, sh_level[i], sh_left[i], now);
			end
		end
		if (sh_tick != '1) sh_tick = sh_tick + 1'b1;
		all_done = 1'b1;
		for (int i = 0; i < used; i++)
			if (sh_status[i] != ST_DONE) all_done = 1'b0;
		if (all_done && used > 0) add_event(EV_ALLDONE, 0, '0, '0, now);
		if (expected_events.size() > first)
			expected_events[expected_events.size()-1].last = 1'b1;
	endtask

	task automatic report(string what);
		errors++;
		$display("%0t: %s", $realtime, what);
	endtask

	// driver: bursts of requests with random gaps
	sched_req_t cur_req;
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) schedule_request(cur_req);
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					in_ch.mode <= cur_req.mode;
					in_ch.slot <= cur_req.slot;
					in_ch.arrival <= cur_req.arrival;
					in_ch.burst <= cur_req.burst;
					in_ch.level <= cur_req.level;
					in_ch.valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left--;
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern is redrawn at random from four modes
	int stall_cnt = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			stall_cnt++;
			if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2: out_ch.ready <= (stall_cnt % 8 < 2);
				default: out_ch.ready <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// monitor
	sched_event_t exp_ev;
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_events.size() == 0) begin
				report($sformatf("unexpected event %0d slot %0d", out_ch.event_res,
					out_ch.task_res));
			end else begin
				exp_ev = expected_events.pop_front();
				if (out_ch.event_res !== exp_ev.event_res)
					report($sformatf("event_res %0d, want %0d", out_ch.event_res, exp_ev.event_res));
				if (out_ch.task_res !== exp_ev.task_res)
					report($sformatf("task_res %0d, want %0d", out_ch.task_res, exp_ev.task_res));
				if (out_ch.task_level !== exp_ev.task_level)
					report($sformatf("task_level %0d, want %0d", out_ch.task_level,
						exp_ev.task_level));
				if (out_ch.remaining !== exp_ev.remaining)
					report($sformatf("remaining %0d, want %0d", out_ch.remaining, exp_ev.remaining));
				if (out_ch.now !== exp_ev.now)
					report($sformatf("now %0d, want %0d", out_ch.now, exp_ev.now));
				if (out_ch.last !== exp_ev.last)
					report($sformatf("last %0b, want %0b", out_ch.last, exp_ev.last));
			end
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TASK_COUNT: cfg_task_count = data[CNT_W-1:0];
			REG_WAIT_LIMIT: cfg_wait_limit = data[TIME_W-1:0];
			REG_LOWEST_LEVEL: cfg_lowest_level = data[LVL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int tc, int wl, int ll);
		apb_write(REG_TASK_COUNT, tc);
		apb_write(REG_WAIT_LIMIT, wl);
		apb_write(REG_LOWEST_LEVEL, ll);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || in_ch.valid || expected_events.size() != 0);
		// a tick with no event may still be running
		repeat (80) @(negedge clk);
	endtask

	task automatic push_load(int s, int arr, int b, int lv);
		sched_req_t rq;
		rq.mode = 1'b0;
		rq.slot = s[SLOT_W-1:0];
		rq.arrival = arr[TIME_W-1:0];
		rq.burst = b[TIME_W-1:0];
		rq.level = lv[LVL_W-1:0];
		pending_reqs.push_back(rq);
	endtask

	task automatic push_tick();
		sched_req_t rq;
		rq.mode = 1'b1;
		rq.slot = SLOT_W'($urandom);
		rq.arrival = TIME_W'($urandom);
		rq.burst = TIME_W'($urandom);
		rq.level = LVL_W'($urandom);
		pending_reqs.push_back(rq);
		gen_tick++;
	endtask

	task automatic push_random(int n);
		int b;
		int arr;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) != 0) begin
				push_tick();
			end else begin
				case ($urandom_range(0, 5))
					0: b = 0;
					1: b = $urandom_range(0, 65535);
					default: b = $urandom_range(1, 8);
				endcase
				arr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
					: gen_tick + $urandom_range(0, 6);
				push_load($urandom_range(0, 15), arr, b,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// every slot is loaded before any tick reads it
		push_load(0, 0, 0, 0);
		push_load(1, 0, 65535, 7);
		push_load(2, 1, 3, 6);
		push_load(3, 0, 4, 1);
		push_load(4, 2, 2, 5);
		push_load(5, 65535, 65535, 2);
		push_load(6, 0, 1, 0);
		push_load(7, 3, 6, 4);
		for (int s = 8; s < NUM_SLOTS; s++)
			push_load(s, $urandom_range(0, 4), $urandom_range(1, 5), $urandom_range(1, 3));
		wait_idle();
		set_config(16, 4, 7);
		for (int k = 0; k < 10; k++) push_tick();
		push_load(15, gen_tick, 2, 3);
		push_tick();
		push_tick();
		wait_idle();
		set_config(31, 1, 1);
		push_random(25);
		wait_idle();
		set_config(0, 65535, 7);
		push_random(15);
		wait_idle();
		set_config(5, 3, 2);
		push_random(30);
		wait_idle();
		set_config(16, 65535, 3);
		push_random(30);
		wait_idle();
		set_config(1, 10, 5);
		push_random(20);
		wait_idle();
		set_config(16, 20, 5);
		push_random(30);
		wait_idle();
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
